// ===== rtl/bbsf_pkg.sv =====
// Shared types, constants and register indexes of the ball and beam controller.
`timescale 1ns / 1ps

package bbsf_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SETPOINT   = 3'd0;
  localparam logic [2:0] REG_ACTIVE     = 3'd1;
  localparam logic [2:0] REG_GAIN_POS   = 3'd2;
  localparam logic [2:0] REG_GAIN_VEL   = 3'd3;
  localparam logic [2:0] REG_GAIN_INT   = 3'd4;
  localparam logic [2:0] REG_CAL_SCALE  = 3'd5;
  localparam logic [2:0] REG_CAL_OFFSET = 3'd6;

  // Register reset values.
  localparam logic [14:0]        RST_SETPOINT   = 15'd3840;
  localparam logic               RST_ACTIVE     = 1'b0;
  localparam logic signed [23:0] RST_GAIN_POS   = -24'sd169319;
  localparam logic signed [23:0] RST_GAIN_VEL   = -24'sd53028;
  localparam logic signed [23:0] RST_GAIN_INT   = -24'sd1294;
  localparam logic [15:0]        RST_CAL_SCALE  = 16'd4088;
  localparam logic [14:0]        RST_CAL_OFFSET = 15'd671;

  // Loop constants.
  localparam logic [15:0]        RANGE_LIMIT_MM = 16'd2000;
  localparam logic [14:0]        POS_MAX        = 15'h7FFF;
  localparam logic signed [41:0] DRIVE_LIMIT    = 42'sd15360;
  localparam logic signed [16:0] NEUTRAL_Q8     = 17'sd30720;
  localparam logic [7:0]         ANGLE_NEUTRAL  = 8'd120;
  localparam logic [7:0]         ANGLE_MAX      = 8'd180;

  typedef struct packed {
    logic [14:0]        setpoint;
    logic               active;
    logic signed [23:0] gain_pos;
    logic signed [23:0] gain_vel;
    logic signed [23:0] gain_int;
    logic [15:0]        cal_scale;
    logic [14:0]        cal_offset;
  } bbsf_cfg_t;

  // Plant state handed from the estimator to the control law.
  typedef struct packed {
    logic [14:0]        position;
    logic signed [20:0] velocity;
    logic signed [31:0] error_sum;
  } bbsf_state_t;

endpackage

// ===== rtl/bbsf_estimator.sv =====
// Calibration, velocity and integrator stages of the ball and beam controller.
`timescale 1ns / 1ps

module bbsf_estimator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bbsf_pkg::bbsf_cfg_t  cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [15:0]          range_mm,
  input  logic                 range_ok,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output bbsf_pkg::bbsf_state_t dn_state
);
  import bbsf_pkg::*;

  logic        a_v_r, a_v_nxt;
  logic [31:0] prod_r;
  logic        upd_r;
  logic        a_ready;
  logic        b_v_r, b_v_nxt;
  logic        b_ready;
  logic        b_load;
  logic [14:0] last_pos_r, last_pos_nxt;
  logic signed [31:0] esum_r, esum_nxt;
  bbsf_state_t st_r;

  logic signed [25:0] p_raw;
  logic [14:0]        pos_cal;
  logic [14:0]        pos;
  logic signed [15:0] diff;
  logic signed [20:0] diff_x;
  logic signed [20:0] vel;
  logic signed [32:0] esum_sum;
  logic signed [31:0] esum_sat;

  assign b_ready  = !b_v_r || dn_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign b_load   = a_v_r && b_ready;
  assign up_ready = a_ready;
  assign a_v_nxt  = a_ready ? up_valid : a_v_r;
  assign b_v_nxt  = b_ready ? a_v_r : b_v_r;

  // Stage A: raw product and reading validity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
    end
    if (a_ready && up_valid) begin
      prod_r <= 32'(range_mm) * 32'(cfg.cal_scale);
      upd_r  <= range_ok && (range_mm < RANGE_LIMIT_MM);
    end
  end

  // Stage B: position, velocity and integrator.
  assign p_raw = $signed({2'b00, prod_r[31:8]}) - $signed({11'd0, cfg.cal_offset});

  always_comb begin
    if (p_raw < 26'sd0) begin
      pos_cal = 15'd0;
    end else if (p_raw > $signed({11'd0, POS_MAX})) begin
      pos_cal = POS_MAX;
    end else begin
      pos_cal = p_raw[14:0];
    end
  end

  assign pos    = upd_r ? pos_cal : last_pos_r;
  assign diff   = $signed({1'b0, pos}) - $signed({1'b0, last_pos_r});
  assign diff_x = 21'(diff);
  assign vel    = (diff_x <<< 4) + (diff_x <<< 2);

  assign esum_sum = 33'(esum_r) + 33'($signed({1'b0, cfg.setpoint}) - $signed({1'b0, pos}));

  always_comb begin
    if (esum_sum[32] != esum_sum[31]) begin
      esum_sat = esum_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      esum_sat = esum_sum[31:0];
    end
  end

  // The integrator clears when the loop is off; the drive still sees the held value.
  assign last_pos_nxt = b_load ? pos : last_pos_r;
  assign esum_nxt     = !b_load ? esum_r : (cfg.active ? esum_sat : 32'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r      <= 1'b0;
      last_pos_r <= 15'd0;
      esum_r     <= 32'sd0;
    end else begin
      b_v_r      <= b_v_nxt;
      last_pos_r <= last_pos_nxt;
      esum_r     <= esum_nxt;
    end
    if (b_load) begin
      st_r.position  <= pos;
      st_r.velocity  <= vel;
      st_r.error_sum <= cfg.active ? esum_sat : esum_r;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_state = st_r;

endmodule

// ===== rtl/bbsf_control_law.sv =====
// Gain products, drive clamp and servo angle stages of the ball and beam controller.
`timescale 1ns / 1ps

module bbsf_control_law (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bbsf_pkg::bbsf_cfg_t   cfg,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  bbsf_pkg::bbsf_state_t up_state,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [7:0]            servo_angle,
  output logic [14:0]           position,
  output logic [20:0]           velocity,
  output logic [14:0]           drive
);
  import bbsf_pkg::*;

  logic c_v_r, c_v_nxt, c_ready;
  logic d_v_r, d_v_nxt, d_ready;
  logic d_load;

  logic signed [39:0] prod_pos, prod_pos_r;
  logic signed [44:0] prod_vel, prod_vel_r;
  logic signed [55:0] prod_int, prod_int_r;
  logic [14:0]        pos_c_r;
  logic signed [20:0] vel_c_r;

  logic signed [57:0] acc;
  logic signed [41:0] u_full;
  logic signed [14:0] u_clamp;
  logic signed [16:0] angle_q8;
  logic [7:0]         angle;

  logic [7:0]  angle_r;
  logic [14:0] pos_d_r;
  logic [20:0] vel_d_r;
  logic [14:0] drive_r;

  assign d_ready  = !d_v_r || dn_ready;
  assign c_ready  = !c_v_r || d_ready;
  assign d_load   = c_v_r && d_ready;
  assign up_ready = c_ready;
  assign c_v_nxt  = c_ready ? up_valid : c_v_r;
  assign d_v_nxt  = d_ready ? c_v_r : d_v_r;

  // Stage C: the three gain products.
  assign prod_pos = cfg.gain_pos * $signed({1'b0, up_state.position});
  assign prod_vel = cfg.gain_vel * up_state.velocity;
  assign prod_int = cfg.gain_int * up_state.error_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= c_v_nxt;
    end
    if (c_ready && up_valid) begin
      prod_pos_r <= prod_pos;
      prod_vel_r <= prod_vel;
      prod_int_r <= prod_int;
      pos_c_r    <= up_state.position;
      vel_c_r    <= up_state.velocity;
    end
  end

  // Stage D: sum, floor shift by 16, clamp and angle.
  assign acc    = 58'(prod_int_r) - 58'(prod_pos_r) - 58'(prod_vel_r);
  assign u_full = acc[57:16];

  always_comb begin
    if (u_full > DRIVE_LIMIT) begin
      u_clamp = 15'(DRIVE_LIMIT);
    end else if (u_full < -DRIVE_LIMIT) begin
      u_clamp = 15'(-DRIVE_LIMIT);
    end else begin
      u_clamp = u_full[14:0];
    end
  end

  // The clamped drive keeps this difference positive, so a shift truncates correctly.
  assign angle_q8 = NEUTRAL_Q8 - 17'(u_clamp);

  always_comb begin
    if (!cfg.active) begin
      angle = ANGLE_NEUTRAL;
    end else if (angle_q8[15:8] > ANGLE_MAX) begin
      angle = ANGLE_MAX;
    end else begin
      angle = angle_q8[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else begin
      d_v_r <= d_v_nxt;
    end
    if (d_load) begin
      angle_r <= angle;
      pos_d_r <= pos_c_r;
      vel_d_r <= vel_c_r;
      drive_r <= u_clamp;
    end
  end

  assign dn_valid    = d_v_r;
  assign servo_angle = angle_r;
  assign position    = pos_d_r;
  assign velocity    = vel_d_r;
  assign drive       = drive_r;

endmodule

// ===== rtl/ball_beam_state_feedback_controller.sv =====
// Ball and beam state feedback controller with integral action: top level.
//
// Input words carry one range sample: in_tdata holds range_mm, in_tuser holds
// range_ok. Each accepted word yields exactly one result word holding servo
// angle, calibrated position, velocity and clamped drive.
// The datapath is a four stage pipeline: product register, estimator
// register (position, velocity, integrator), gain product register and
// output register. A result is offered once it reaches the output register.
// One word per cycle is sustained while out_tready stays high, since the
// integrator loop closes within the estimator stage.
// Each stage has its own valid flag, so input words keep flowing into empty
// stages while a result waits; when out_tready stays low the pipeline fills
// and in_tready drops after four words are held.
// Synchronous active low reset empties the pipeline, clears the stored
// position and integrator and loads the register defaults. Registers are
// written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while no word is in flight, as the block itself does not enforce this.
`timescale 1ns / 1ps

module ball_beam_state_feedback_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] range_mm
  input  logic        in_tuser,   // [0] range_ok
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] servo_angle, [22:8] position, [43:23] velocity, [58:44] drive, zero above
  output logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import bbsf_pkg::*;

  bbsf_cfg_t   cfg_r;
  bbsf_state_t est_state;
  logic        est_valid;
  logic        law_ready;
  logic [7:0]  servo_angle;
  logic [14:0] position;
  logic [20:0] velocity;
  logic [14:0] drive;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint   <= RST_SETPOINT;
      cfg_r.active     <= RST_ACTIVE;
      cfg_r.gain_pos   <= RST_GAIN_POS;
      cfg_r.gain_vel   <= RST_GAIN_VEL;
      cfg_r.gain_int   <= RST_GAIN_INT;
      cfg_r.cal_scale  <= RST_CAL_SCALE;
      cfg_r.cal_offset <= RST_CAL_OFFSET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETPOINT:   cfg_r.setpoint   <= cfg_wdata[14:0];
        REG_ACTIVE:     cfg_r.active     <= cfg_wdata[0];
        REG_GAIN_POS:   cfg_r.gain_pos   <= cfg_wdata;
        REG_GAIN_VEL:   cfg_r.gain_vel   <= cfg_wdata;
        REG_GAIN_INT:   cfg_r.gain_int   <= cfg_wdata;
        REG_CAL_SCALE:  cfg_r.cal_scale  <= cfg_wdata[15:0];
        REG_CAL_OFFSET: cfg_r.cal_offset <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  bbsf_estimator u_est (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .range_mm (in_tdata),
    .range_ok (in_tuser),
    .dn_valid (est_valid),
    .dn_ready (law_ready),
    .dn_state (est_state)
  );

  bbsf_control_law u_law (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .up_valid    (est_valid),
    .up_ready    (law_ready),
    .up_state    (est_state),
    .dn_valid    (out_tvalid),
    .dn_ready    (out_tready),
    .servo_angle (servo_angle),
    .position    (position),
    .velocity    (velocity),
    .drive       (drive)
  );

  assign out_tdata = {5'd0, drive, velocity, position, servo_angle};

endmodule

// ===== rtl/bbsf_checker.sv =====
// Port level checks of the ball and beam controller and their bind.
`timescale 1ns / 1ps

module bbsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // A result word held back by the receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word offered right after reset");

  // The clamped drive keeps the servo angle between 60 and 180 degrees.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] >= 8'd60) && (out_tdata[7:0] <= 8'd180))
    else $error("servo angle out of range");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[58:44]) <= 15'sd15360)
                && ($signed(out_tdata[58:44]) >= -15'sd15360))
    else $error("drive out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:59] == 5'd0))
    else $error("padding bits of result word not zero");

endmodule

bind ball_beam_state_feedback_controller bbsf_checker u_bbsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
